[sv/l4paf_pkg.sv]
// Shared types and constants for the L4 port allowlist filter.
package l4paf_pkg;

	// EtherTypes and transport protocols
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// Frame byte offsets
	localparam logic [6:0] OFF_ETYPE_HI  = 7'd12;
	localparam logic [6:0] OFF_ETYPE_LO  = 7'd13;
	localparam logic [6:0] OFF_L3_START  = 7'd14;
	localparam logic [6:0] OFF_V4_PROTO  = 7'd23;
	localparam logic [6:0] OFF_V6_NEXT   = 7'd20;
	localparam logic [6:0] OFF_V6_L4     = 7'd54;
	localparam logic [6:0] OFF_MAX       = 7'd127;

	// Minimum lengths
	localparam logic [7:0] LEN_ETH_MIN = 8'd14;
	localparam logic [7:0] LEN_V4_MIN  = 8'd34;
	localparam logic [7:0] LEN_V6_MIN  = 8'd54;
	localparam logic [7:0] LEN_TCP_HDR = 8'd20;
	localparam logic [7:0] LEN_UDP_HDR = 8'd8;

	// Port table geometry
	localparam int TABLE_SLOTS     = 12;
	localparam int ENTRIES_PER_REG = 4;
	localparam int PORT_W          = 16;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ALLOW     = 3'd0,
		REG_DENY      = 3'd1,
		REG_PORT_LOW  = 3'd2,
		REG_PORT_MID  = 3'd3,
		REG_PORT_HIGH = 3'd4
	} reg_idx_t;

	// Verdict codes
	localparam logic [1:0] VERDICT_UNSPEC = 2'd0;
	localparam logic [1:0] VERDICT_TRUNC  = 2'd1;
	localparam logic [1:0] VERDICT_ALLOW  = 2'd2;
	localparam logic [1:0] VERDICT_DENY   = 2'd3;

	// Fixed action codes
	localparam logic signed [8:0] ACT_UNSPEC = -9'sd1;
	localparam logic signed [8:0] ACT_SHOT   = 9'sd2;

	// Queue depth between parser and decision stage
	localparam int QUEUE_DEPTH = 2;

	// Parser classification of a finished frame
	typedef enum logic [1:0] {
		KIND_UNSPEC,
		KIND_SHOT,
		KIND_CHECK
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [PORT_W-1:0] src;
		logic [PORT_W-1:0] dst;
	} summary_t;

endpackage

[sv/l4paf_front.sv]
// Byte-serial frame parser: tracks headers, captures ports, classifies the frame.
module l4paf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          frame_byte,
	input  logic                is_last,
	output logic                push,
	output l4paf_pkg::summary_t push_data
);
	import l4paf_pkg::*;

	logic [6:0]  off_q;
	logic [15:0] etype_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;

	logic [15:0] etype_n;
	logic [3:0]  hw_n;
	logic [7:0]  proto_n;
	logic [15:0] src_n;
	logic [15:0] dst_n;
	logic        is4;
	logic        is6;
	logic [6:0]  toff;
	logic [6:0]  diff;

	logic [7:0]  len;
	logic [7:0]  tlast;
	logic [7:0]  need;
	logic        l3_known;
	logic        l3_short;
	kind_t       kind;

	// Header field tracking for the current byte
	always_comb begin
		etype_n = etype_q;
		if (off_q == OFF_ETYPE_HI) begin
			etype_n = {frame_byte, etype_q[7:0]};
		end else if (off_q == OFF_ETYPE_LO) begin
			etype_n = {etype_q[15:8], frame_byte};
		end
		is4 = (etype_n == ETYPE_IPV4) && (off_q >= OFF_L3_START);
		is6 = (etype_n == ETYPE_IPV6) && (off_q >= OFF_L3_START);
		hw_n = (is4 && off_q == OFF_L3_START) ? frame_byte[3:0] : hw_q;
		proto_n = ((is4 && off_q == OFF_V4_PROTO) || (is6 && off_q == OFF_V6_NEXT))
			? frame_byte : proto_q;
		toff = is4 ? (OFF_L3_START + {1'b0, hw_n, 2'b00}) : OFF_V6_L4;
		diff = off_q - toff;
		src_n = src_q;
		dst_n = dst_q;
		if ((is4 || is6) && off_q >= toff) begin
			unique case (diff)
				7'd0: src_n = {frame_byte, src_q[7:0]};
				7'd1: src_n = {src_q[15:8], frame_byte};
				7'd2: dst_n = {frame_byte, dst_q[7:0]};
				7'd3: dst_n = {dst_q[15:8], frame_byte};
				default: ;
			endcase
		end
	end

	// End-of-frame classification; the EtherType takes in the current byte,
	// the other fields only matter once the frame is past them
	always_comb begin
		len = {1'b0, off_q} + 8'd1;
		l3_known = 1'b0;
		l3_short = 1'b0;
		tlast = {1'b0, OFF_V6_L4};
		if (etype_n == ETYPE_IPV4) begin
			l3_known = 1'b1;
			l3_short = len < LEN_V4_MIN;
			tlast = {1'b0, OFF_L3_START} + {2'b00, hw_q, 2'b00};
		end else if (etype_n == ETYPE_IPV6) begin
			l3_known = 1'b1;
			l3_short = len < LEN_V6_MIN;
		end
		need = 8'd0;
		if (proto_q == PROTO_TCP) begin
			need = tlast + LEN_TCP_HDR;
		end else if (proto_q == PROTO_UDP) begin
			need = tlast + LEN_UDP_HDR;
		end
		priority if (len < LEN_ETH_MIN || !l3_known) begin
			kind = KIND_UNSPEC;
		end else if (l3_short) begin
			kind = KIND_SHOT;
		end else if (need == 8'd0) begin
			kind = KIND_UNSPEC;
		end else if (len < need) begin
			kind = KIND_SHOT;
		end else begin
			kind = KIND_CHECK;
		end
	end

	assign push = accept && is_last;
	assign push_data = '{kind: kind, src: src_q, dst: dst_q};

	// Parser state; cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			etype_q <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
		end else if (accept) begin
			if (is_last) begin
				off_q   <= '0;
				etype_q <= '0;
				hw_q    <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
			end else begin
				if (off_q != OFF_MAX) begin
					off_q <= off_q + 7'd1;
				end
				etype_q <= etype_n;
				hw_q    <= hw_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
			end
		end
	end

endmodule

[sv/l4paf_queue.sv]
// Two-entry queue of frame summaries between parser and decision stage.
module l4paf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  l4paf_pkg::summary_t push_data,
	output logic                full,
	input  logic                pop,
	output l4paf_pkg::summary_t head,
	output logic                empty
);
	import l4paf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	summary_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue empty after push");

endmodule

[sv/l4paf_back.sv]
// Decision stage: port table lookup, action select and output register.
module l4paf_back #(
	parameter int TABLE_ENTRIES = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  l4paf_pkg::summary_t          head,
	input  logic                         empty,
	output logic                         pop,
	input  logic [7:0]                   allow_action,
	input  logic [7:0]                   deny_action,
	input  logic [TABLE_ENTRIES-1:0][15:0] port_table,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   verdict,
	output logic signed [8:0]            action,
	output logic [15:0]                  source_port,
	output logic [15:0]                  dest_port
);
	import l4paf_pkg::*;

	logic        valid_q;
	logic [1:0]  verdict_q;
	logic [8:0]  action_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;

	logic        hit;
	logic [1:0]  verdict_n;
	logic [8:0]  action_n;
	logic [15:0] src_n;
	logic [15:0] dst_n;

	// Parallel compare of both ports against every table entry
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit = hit || (port_table[i] == head.src) || (port_table[i] == head.dst);
		end
	end

	// Verdict and action select
	always_comb begin
		src_n = '0;
		dst_n = '0;
		unique case (head.kind)
			KIND_SHOT: begin
				verdict_n = VERDICT_TRUNC;
				action_n  = ACT_SHOT;
			end
			KIND_CHECK: begin
				src_n = head.src;
				dst_n = head.dst;
				if (hit) begin
					verdict_n = VERDICT_ALLOW;
					action_n  = {1'b0, allow_action};
				end else begin
					verdict_n = VERDICT_DENY;
					action_n  = {1'b0, deny_action};
				end
			end
			default: begin
				verdict_n = VERDICT_UNSPEC;
				action_n  = ACT_UNSPEC;
			end
		endcase
	end

	assign pop = !empty && (!valid_q || !out_stall);

	// Output word register
	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_n;
			action_q  <= action_n;
			src_q     <= src_n;
			dst_q     <= dst_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid   = valid_q;
	assign verdict     = verdict_q;
	assign action      = $signed(action_q);
	assign source_port = src_q;
	assign dest_port   = dst_q;

	a_unspec_act: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && verdict_q == VERDICT_UNSPEC) |-> (action_q == ACT_UNSPEC && src_q == '0))
		else $error("unspecified verdict with wrong action or port");

	a_trunc_act: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && verdict_q == VERDICT_TRUNC) |-> (action_q == ACT_SHOT && dst_q == '0))
		else $error("truncated verdict with wrong action or port");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |=> (valid_q && $stable(verdict_q) && $stable(action_q)))
		else $error("output word changed under stall");

endmodule

[sv/l4_port_allowlist_filter_core.sv]
// Top level of the TCP/UDP port allowlist filter: configuration and stage wiring.
//
// Frames enter one byte per word on the input channel (frame_byte, is_last),
// starting at the destination MAC. A word is taken at a clock edge where
// in_valid is high and in_stall low; one byte is taken each cycle this holds.
// Each word with is_last set yields exactly one output word (verdict, action,
// source_port, dest_port); other bytes yield nothing.
// When the last byte is taken its summary enters the queue; the decision stage
// pops it through the table compare into the output register and raises
// out_valid, the pop waiting while a stalled output word is held.
// Throughput: one byte per cycle, one verdict per cycle for back-to-back
// one-byte frames while out_stall is low (parser register, combinational compare).
// The parser hands each finished frame to a two-entry queue; the decision
// stage drains it into the output register. When the receiver holds out_stall
// the output word holds, the queue fills, and in_stall rises only once the
// queue is full, so parsing of a following frame runs on meanwhile.
// Reset clears parser state, the queue and the output valid, and loads the
// registers with allow action 255, deny action 2 and an all-zero port table.
// The user writes configuration via cfg_write/cfg_index/cfg_data only while idle.
module l4_port_allowlist_filter_core #(
	parameter int TABLE_ENTRIES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         frame_byte,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         verdict,
	output logic signed [8:0]  action,
	output logic [15:0]        source_port,
	output logic [15:0]        dest_port
);
	import l4paf_pkg::*;

	logic [7:0]                     allow_q;
	logic [7:0]                     deny_q;
	logic [TABLE_ENTRIES-1:0][15:0] table_q;

	logic     accept;
	logic     push;
	summary_t push_data;
	logic     full;
	logic     pop;
	summary_t head;
	logic     empty;

	// Action registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 8'd255;
			deny_q  <= 8'd2;
		end else if (cfg_write) begin
			if (cfg_index == REG_ALLOW) begin
				allow_q <= cfg_data[7:0];
			end
			if (cfg_index == REG_DENY) begin
				deny_q <= cfg_data[7:0];
			end
		end
	end

	// Port table entries, four to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q <= '0;
		end else if (cfg_write) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (cfg_index == 3'(int'(REG_PORT_LOW) + i / ENTRIES_PER_REG)) begin
					table_q[i] <= cfg_data[(i % ENTRIES_PER_REG) * PORT_W +: PORT_W];
				end
			end
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	l4paf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.is_last    (is_last),
		.push       (push),
		.push_data  (push_data)
	);

	l4paf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	l4paf_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.allow_action (allow_q),
		.deny_action  (deny_q),
		.port_table   (table_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.action       (action),
		.source_port  (source_port),
		.dest_port    (dest_port)
	);

endmodule
